// File: rtl/sitrd_pkg.sv
// Shared types, constants and helpers for the signed integer to radix digits block.
// No dependencies; imported by every module of the block.
`default_nettype none

package sitrd_pkg;

  localparam int MAG_W       = 32;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;
  localparam int LEN_W       = 5;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int SLOTS       = 16;
  localparam int MAX_DIGITS  = 32;
  localparam int CNT_W       = 6;
  localparam int BYTE_STEPS  = MAG_W / 8;
  localparam int STEP_W      = 2;

  localparam logic [LEN_W-1:0]  MAX_RADIX  = 5'd16;
  localparam logic [LEN_W-1:0]  MIN_RADIX  = 5'd2;
  localparam logic [CHAR_W-1:0] CHAR_LOW   = 8'd33;
  localparam logic [CHAR_W-1:0] CHAR_HIGH  = 8'd126;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA_LOWER  = 2'd0,
    CFG_ALPHA_UPPER  = 2'd1,
    CFG_ALPHA_LENGTH = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIVIDE,
    B_SIGN,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    logic             negative;
    logic [MAG_W-1:0] magnitude;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Radix in use: length register saturated to the cap.
  function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
    eff_length = (len > MAX_RADIX) ? MAX_RADIX : len;
  endfunction

  function automatic logic [CHAR_W-1:0] alpha_char(input logic [CFG_W-1:0]   lower,
                                                   input logic [CFG_W-1:0]   upper,
                                                   input logic [DIGIT_W-1:0] idx);
    logic [CFG_W-1:0] word;
    word       = idx[DIGIT_W-1] ? upper : lower;
    alpha_char = word[idx[DIGIT_W-2:0]*CHAR_W +: CHAR_W];
  endfunction

endpackage

`default_nettype wire

// File: rtl/signed_integer_to_radix_digits_top.sv
// Operation: the back end takes a request from the queue and divides it by the radix,
// retiring one quotient byte per cycle; then a '-' sign, if negative, and the digits
// follow one per cycle, most significant first. The back end finishes one request
// before it takes the next from the queue.
// Reset (rst, synchronous, high) clears the alphabet registers, queue and sequencer.
// Results cannot be stalled by the receiver.
`default_nettype none

module signed_integer_to_radix_digits_top (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  // request channel
  input  wire logic                                    start,
  output logic                                         busy,
  input  wire logic signed [sitrd_pkg::MAG_W-1:0]      number,
  // result channel
  output logic                                         strobe,
  output logic [sitrd_pkg::CHAR_W-1:0]                 character,
  output logic                                         last_character,
  // configuration write channel
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [sitrd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [sitrd_pkg::CFG_W-1:0]             cfg_data
);
  import sitrd_pkg::*;

  // Alphabet registers
  logic [CFG_W-1:0] alphabet_lower;
  logic [CFG_W-1:0] alphabet_upper;
  logic [LEN_W-1:0] alphabet_length;
  logic [LEN_W-1:0] radix;

  q_entry_t  front_entry;
  logic      front_ok;
  logic      accept;
  logic      enq;
  logic      deq;
  q_entry_t  q_data;
  q_status_t q_status;

  // Config is always accepted; unknown index is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_lower  <= '0;
      alphabet_upper  <= '0;
      alphabet_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ALPHA_LOWER:  alphabet_lower  <= cfg_data;
        CFG_ALPHA_UPPER:  alphabet_upper  <= cfg_data;
        CFG_ALPHA_LENGTH: alphabet_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign radix = eff_length(alphabet_length);

  // Front: takes a request whenever the queue has room. A bad alphabet means
  // the request is dropped here and produces no output at all.
  sitrd_front u_front (
    .number      (number),
    .alpha_lower (alphabet_lower),
    .alpha_upper (alphabet_upper),
    .radix       (radix),
    .entry       (front_entry),
    .item_ok     (front_ok)
  );

  assign busy   = q_status.full;
  assign accept = start && !busy;
  assign enq    = accept && front_ok;

  sitrd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .enq      (enq),
    .enq_data (front_entry),
    .deq      (deq),
    .deq_data (q_data),
    .status   (q_status)
  );

  // Back: divide, stack digits, emit sign then digits MSD first.
  sitrd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_status       (q_status),
    .q_data         (q_data),
    .deq            (deq),
    .alpha_lower    (alphabet_lower),
    .alpha_upper    (alphabet_upper),
    .radix          (radix),
    .strobe         (strobe),
    .character      (character),
    .last_character (last_character)
  );

`ifndef SYNTHESIS
  a_last_has_strobe: assert property (@(posedge clk) disable iff (rst)
    last_character |-> strobe)
    else $error("last_character without strobe");

  a_chars_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_character |=> strobe)
    else $error("gap inside a character burst");

  a_enq_lands: assert property (@(posedge clk) disable iff (rst)
    enq |=> !q_status.empty)
    else $error("queued request lost");

  a_deq_nonempty: assert property (@(posedge clk) disable iff (rst)
    deq |-> !q_status.empty)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// File: rtl/sitrd_front.sv
// Front end: checks the configured alphabet and forms sign and magnitude of a request.
// Depends on sitrd_pkg.
`default_nettype none

module sitrd_front (
  input  wire logic signed [sitrd_pkg::MAG_W-1:0] number,
  input  wire logic [sitrd_pkg::CFG_W-1:0]        alpha_lower,
  input  wire logic [sitrd_pkg::CFG_W-1:0]        alpha_upper,
  input  wire logic [sitrd_pkg::LEN_W-1:0]        radix,
  output sitrd_pkg::q_entry_t                      entry,
  output logic                                     item_ok
);
  import sitrd_pkg::*;

  logic [CHAR_W-1:0] chars [SLOTS];
  logic [SLOTS-1:0]  in_use;
  logic [SLOTS-1:0]  bad_char;
  logic [SLOTS-1:0]  dup_char;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      chars[i]    = alpha_char(alpha_lower, alpha_upper, DIGIT_W'(i));
      in_use[i]   = (LEN_W'(i) < radix);
      bad_char[i] = in_use[i] && (chars[i] < CHAR_LOW || chars[i] > CHAR_HIGH ||
                                  chars[i] == CHAR_PLUS || chars[i] == CHAR_MINUS);
    end
    // Pair (i, k) with i < k: slot k in use implies slot i in use.
    for (int i = 0; i < SLOTS; i++) begin
      dup_char[i] = 1'b0;
      for (int k = i + 1; k < SLOTS; k++) begin
        if (in_use[k] && chars[k] == chars[i]) begin
          dup_char[i] = 1'b1;
        end
      end
    end
  end

  assign item_ok = (radix >= MIN_RADIX) && (bad_char == '0) && (dup_char == '0);

  always_comb begin
    entry.negative  = number[MAG_W-1];
    entry.magnitude = number[MAG_W-1] ? (MAG_W'(0) - MAG_W'(number)) : MAG_W'(number);
  end

endmodule

`default_nettype wire

// File: rtl/sitrd_queue.sv
// Two-entry FIFO between front and back end.
// Depends on sitrd_pkg.
`default_nettype none

module sitrd_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 enq,
  input  wire sitrd_pkg::q_entry_t  enq_data,
  input  wire logic                 deq,
  output sitrd_pkg::q_entry_t       deq_data,
  output sitrd_pkg::q_status_t      status
);
  import sitrd_pkg::*;

  q_entry_t   slots [2];
  logic       head;
  logic       tail;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (enq) begin
        tail <= ~tail;
      end
      if (deq) begin
        head <= ~head;
      end
      count <= count + 2'(enq) - 2'(deq);
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[tail] <= enq_data;
    end
  end

  assign deq_data     = slots[head];
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

endmodule

`default_nettype wire

// File: rtl/sitrd_back.sv
// Back end: repeated division by the radix, one quotient byte a cycle, digits
// stacked and emitted most significant first. Depends on sitrd_pkg.
`default_nettype none

module sitrd_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire sitrd_pkg::q_status_t        q_status,
  input  wire sitrd_pkg::q_entry_t         q_data,
  output logic                             deq,
  input  wire logic [sitrd_pkg::CFG_W-1:0] alpha_lower,
  input  wire logic [sitrd_pkg::CFG_W-1:0] alpha_upper,
  input  wire logic [sitrd_pkg::LEN_W-1:0] radix,
  output logic                             strobe,
  output logic [sitrd_pkg::CHAR_W-1:0]     character,
  output logic                             last_character
);
  import sitrd_pkg::*;

  back_state_t        state, state_next;
  logic [MAG_W-1:0]   work;
  logic [DIGIT_W-1:0] rem;
  logic [STEP_W-1:0]  step;
  logic [CNT_W-1:0]   ndig;
  logic               negative;
  logic [DIGIT_W-1:0] digits [MAX_DIGITS];

  logic [7:0]         qbyte;
  logic [DIGIT_W-1:0] rem_next;
  logic [MAG_W-1:0]   work_next;
  logic               div_done;
  logic               push;
  logic               pop;

  // Eight restoring-division steps on a 4-bit remainder.
  always_comb begin
    logic [DIGIT_W:0]   trial;
    logic [DIGIT_W-1:0] r;
    r = rem;
    for (int j = 7; j >= 0; j--) begin
      trial = {r, work[MAG_W-8+j]};
      if (trial >= radix) begin
        qbyte[j] = 1'b1;
        r        = DIGIT_W'(trial - radix);
      end else begin
        qbyte[j] = 1'b0;
        r        = trial[DIGIT_W-1:0];
      end
    end
    rem_next  = r;
    work_next = {work[MAG_W-9:0], qbyte};
  end

  assign div_done = (state == B_DIVIDE) && (step == STEP_W'(BYTE_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    deq        = 1'b0;
    push       = 1'b0;
    pop        = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_status.empty) begin
          deq        = 1'b1;
          state_next = B_DIVIDE;
        end
      end
      B_DIVIDE: begin
        if (div_done) begin
          push = 1'b1;
          if (work_next == '0) begin
            state_next = negative ? B_SIGN : B_EMIT;
          end
        end
      end
      B_SIGN: begin
        state_next = B_EMIT;
      end
      B_EMIT: begin
        pop = 1'b1;
        if (ndig == CNT_W'(1)) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      ndig <= '0;
    end else begin
      if (deq) begin
        step <= '0;
        ndig <= '0;
      end else if (state == B_DIVIDE) begin
        step <= step + STEP_W'(1);
        if (push) begin
          ndig <= ndig + CNT_W'(1);
        end
      end else if (pop) begin
        ndig <= ndig - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (deq) begin
      work     <= q_data.magnitude;
      negative <= q_data.negative;
      rem      <= '0;
    end else if (state == B_DIVIDE) begin
      work <= work_next;
      rem  <= div_done ? '0 : rem_next;
    end
    if (push) begin
      digits[0] <= rem_next;
      for (int i = 1; i < MAX_DIGITS; i++) begin
        digits[i] <= digits[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        digits[i] <= digits[i+1];
      end
    end
  end

  assign strobe         = (state == B_SIGN) || (state == B_EMIT);
  assign character      = (state == B_SIGN) ? CHAR_MINUS :
                          alpha_char(alpha_lower, alpha_upper, digits[0]);
  assign last_character = (state == B_EMIT) && (ndig == CNT_W'(1));

endmodule

`default_nettype wire

// File: sim/signed_integer_to_radix_digits_top_tb.sv
// Testbench for signed_integer_to_radix_digits_top: writes digit alphabets, sends numbers and
// checks every emitted character against an in-bench predictor held in a small scoreboard.
// Depends on sitrd_pkg and the top-level RTL only.
`timescale 1ns / 100ps

module signed_integer_to_radix_digits_top_tb;
  import sitrd_pkg::*;

  // Index that decodes to no register; writes to it must leave the alphabet untouched.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  localparam logic signed [MAG_W-1:0] NUM_MIN = 32'sh8000_0000;
  localparam logic signed [MAG_W-1:0] NUM_MAX = 32'sh7FFF_FFFF;

  // Hex alphabet "0123456789ABCDEF", first character in the low byte.
  localparam logic [CFG_W-1:0] HEX_LOWER = 64'h3736_3534_3332_3130;
  localparam logic [CFG_W-1:0] HEX_UPPER = 64'h4645_4443_4241_3938;

  // Slowest number: 32 digits plus sign, well within this settle time.
  localparam int DRAIN_SETTLE   = 200;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int RANDOM_PHASES  = 14;
  localparam int ITEMS_PER_PHASE = 24;

  typedef enum int {
    FLAW_NONE,
    FLAW_REPEAT,
    FLAW_LOW,
    FLAW_HIGH,
    FLAW_SIGN
  } flaw_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              is_last;
  } text_char_t;

  // Holds the alphabet registers as the block should see them, and the characters
  // still owed for every number taken so far, oldest first.
  class digit_scoreboard;
    logic [CFG_W-1:0] alpha_lo;
    logic [CFG_W-1:0] alpha_hi;
    logic [LEN_W-1:0] alpha_len;
    text_char_t       expected_text[$];
    int               errors;

    function new();
      alpha_lo  = '0;
      alpha_hi  = '0;
      alpha_len = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_ALPHA_LOWER:  alpha_lo  = data;
        CFG_ALPHA_UPPER:  alpha_hi  = data;
        CFG_ALPHA_LENGTH: alpha_len = data[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [CHAR_W-1:0] digit_char(int unsigned idx);
      logic [2*CFG_W-1:0] all_chars;
      all_chars = {alpha_hi, alpha_lo};
      return all_chars[idx*CHAR_W +: CHAR_W];
    endfunction

    function bit alphabet_ok(int unsigned n);
      logic [CHAR_W-1:0] c;
      int unsigned       i;
      int unsigned       j;
      if (n < 2) return 1'b0;
      for (i = 0; i < n; i++) begin
        c = digit_char(i);
        if (c < CHAR_LOW || c > CHAR_HIGH || c == CHAR_PLUS || c == CHAR_MINUS) return 1'b0;
        for (j = i + 1; j < n; j++)
          if (digit_char(j) == c) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_number(logic signed [MAG_W-1:0] value);
      int unsigned      radix;
      logic [MAG_W-1:0] mag;
      int unsigned      digs[MAX_DIGITS];
      int               nd;
      int               i;
      radix = (alpha_len > MAX_RADIX) ? MAX_RADIX : alpha_len;
      if (!alphabet_ok(radix)) return;
      // unsigned negate keeps the most negative value exact
      mag = value[MAG_W-1] ? (32'd0 - value) : value;
      nd  = 0;
      do begin
        digs[nd] = mag % radix;
        mag      = mag / radix;
        nd++;
      end while (mag != 0);
      if (value[MAG_W-1]) expected_text.push_back('{ch: CHAR_MINUS, is_last: 1'b0});
      for (i = nd - 1; i >= 0; i--)
        expected_text.push_back('{ch: digit_char(digs[i]), is_last: (i == 0)});
    endfunction

    function void check_char(logic [CHAR_W-1:0] ch, logic is_last);
      text_char_t want;
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual %h (last %b)",
                 $time, ch, is_last);
        errors++;
        return;
      end
      want = expected_text.pop_front();
      if (ch !== want.ch) begin
        $display("%0t: character: expected %h, actual %h", $time, want.ch, ch);
        errors++;
      end
      if (is_last !== want.is_last) begin
        $display("%0t: last_character: expected %b, actual %b", $time, want.is_last, is_last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_text.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic signed [MAG_W-1:0]  number;
  logic                     strobe;
  logic [CHAR_W-1:0]        character;
  logic                     last_character;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]         cfg_data;

  digit_scoreboard board = new();
  bit              no_gaps = 1'b0;
  int              cycle_count = 0;

  signed_integer_to_radix_digits_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .number         (number),
    .strobe         (strobe),
    .character      (character),
    .last_character (last_character),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results cannot be held off: every strobed cycle is one character.
  always @(posedge clk) begin
    if (!rst && strobe === 1'b1) board.check_char(character, last_character);
  end

  // Watchdog: a hung handshake or a lost character ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // One request. start stays high on return so back-to-back requests need no
  // low cycle; a gap or a drain lowers it first. drain waits for all output.
  task automatic send_number(input logic signed [MAG_W-1:0] value, input bit drain);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (drain && gap == 0) gap = 1;
    if (gap != 0) begin
      start <= 1'b0;
      while (drain && board.pending() != 0) @(posedge clk);
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    number <= value;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_number(value);
  endtask

  // Invalid alphabets emit nothing; the front drops such requests, and a settle follows the drain.
  task automatic wait_quiet(input int settle);
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    board.write_reg(idx, data);
  endtask

  task automatic reconfigure(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                             input logic [CFG_W-1:0] len_word, input bit unmapped);
    wait_quiet(DRAIN_SETTLE);
    write_reg(CFG_ALPHA_LOWER, lo);
    write_reg(CFG_ALPHA_UPPER, hi);
    write_reg(CFG_ALPHA_LENGTH, len_word);
    // stray index last, so a decode slip would clobber the live alphabet
    if (unmapped) write_reg(CFG_UNMAPPED, {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  // Length in the low bits, noise above so every data bit toggles.
  function automatic logic [CFG_W-1:0] length_word(input int n);
    logic [CFG_W-1:0] w;
    w        = {$urandom, $urandom};
    w[LEN_W-1:0] = n[LEN_W-1:0];
    return w;
  endfunction

  // Distinct printable digits for the used length, junk beyond it; a flaw
  // breaks one used slot.
  function automatic void make_alphabet(input int len, input flaw_t flaw,
                                        output logic [CFG_W-1:0] lo,
                                        output logic [CFG_W-1:0] hi);
    logic [CHAR_W-1:0] chars[SLOTS];
    bit                used[256];
    logic [CHAR_W-1:0] c;
    int                used_len;
    int                pos;
    int                i;
    used_len = (len > SLOTS) ? SLOTS : len;
    for (i = 0; i < 256; i++) used[i] = 1'b0;
    for (i = 0; i < SLOTS; i++) chars[i] = CHAR_W'($urandom);
    for (i = 0; i < used_len; i++) begin
      do c = CHAR_W'($urandom_range(CHAR_LOW, CHAR_HIGH));
      while (used[c] || c == CHAR_PLUS || c == CHAR_MINUS);
      used[c]  = 1'b1;
      chars[i] = c;
    end
    if (flaw != FLAW_NONE && used_len >= 2) begin
      pos = $urandom_range(0, used_len - 1);
      case (flaw)
        FLAW_REPEAT: chars[pos] = chars[(pos + 1) % used_len];
        FLAW_LOW:    chars[pos] = CHAR_W'($urandom_range(0, CHAR_LOW - 1));
        FLAW_HIGH:   chars[pos] = CHAR_W'($urandom_range(CHAR_HIGH + 1, 255));
        default:     chars[pos] = $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
      endcase
    end
    for (i = 0; i < 8; i++) begin
      lo[i*CHAR_W +: CHAR_W] = chars[i];
      hi[i*CHAR_W +: CHAR_W] = chars[i+8];
    end
  endfunction

  // Mix of full-range values, small values, extremes and radix powers (digit-count edges).
  function automatic logic signed [MAG_W-1:0] pick_number(input int radix);
    logic [MAG_W-1:0] p;
    int               k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6: begin
        p = $urandom_range(0, 40);
        return $urandom_range(0, 1) ? -p : p;
      end
      7: begin
        case ($urandom_range(0, 4))
          0:       return NUM_MIN;
          1:       return NUM_MAX;
          2:       return 0;
          3:       return -1;
          default: return NUM_MIN + 1;
        endcase
      end
      default: begin
        p = 1;
        k = $urandom_range(1, 31);
        repeat (k)
          if (radix >= 2 && p <= 32'hFFFF_FFFF / radix) p = p * radix;
        p = p - $urandom_range(0, 1);
        return $urandom_range(0, 1) ? -p : p;
      end
    endcase
  endfunction

  initial begin
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    int               len;
    int               roll;
    flaw_t            flaw;
    int               phase;
    int               k;

    rst       <= 1'b1;
    start     <= 1'b0;
    number    <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    // Alphabet length is zero after reset: nothing comes out.
    send_number(5, 1'b0);
    send_number(-5, 1'b0);

    // Decimal, hex bytes beyond the length ignored; stray index write checked too.
    reconfigure(HEX_LOWER, HEX_UPPER, length_word(10), 1'b1);
    send_number(0, 1'b0);
    send_number(1, 1'b0);
    send_number(-1, 1'b0);
    send_number(NUM_MAX, 1'b0);
    send_number(NUM_MIN, 1'b0);
    send_number(-10, 1'b0);

    // Binary: most negative value gives the longest text.
    reconfigure(HEX_LOWER, HEX_UPPER, length_word(2), 1'b0);
    send_number(NUM_MIN, 1'b0);
    send_number(NUM_MAX, 1'b0);
    send_number(0, 1'b1);

    // Full sixteen-character alphabet.
    reconfigure(HEX_LOWER, HEX_UPPER, length_word(16), 1'b0);
    send_number(32'shDEAD_BEEF, 1'b0);
    send_number(NUM_MIN, 1'b0);

    // Length register all ones: saturates to the cap.
    reconfigure(HEX_LOWER, HEX_UPPER, '1, 1'b0);
    send_number(32'sh1234_5678, 1'b0);

    // Single character: invalid.
    reconfigure(HEX_LOWER, HEX_UPPER, length_word(1), 1'b0);
    send_number(7, 1'b0);

    // Lowest and highest printable digits, junk in every unused byte.
    reconfigure({48'hFFFF_FFFF_FFFF, CHAR_HIGH, CHAR_LOW}, '1, length_word(2), 1'b0);
    send_number(-6, 1'b0);

    // Broken alphabets: sign characters, just outside the printable range, repeat.
    reconfigure({48'h0, CHAR_MINUS, 8'h30}, '0, length_word(2), 1'b0);
    send_number(3, 1'b0);
    reconfigure({48'h0, CHAR_PLUS, 8'h41}, '0, length_word(2), 1'b0);
    send_number(3, 1'b0);
    reconfigure({48'h0, 8'h31, CHAR_LOW - 8'd1}, '0, length_word(2), 1'b0);
    send_number(3, 1'b0);
    reconfigure({48'h0, CHAR_HIGH + 8'd1, 8'h31}, '0, length_word(2), 1'b0);
    send_number(3, 1'b0);
    reconfigure({32'h0, 8'h41, 8'h43, 8'h42, 8'h41}, '0, length_word(4), 1'b0);
    send_number(3, 1'b0);
    reconfigure('1, '0, length_word(3), 1'b0);
    send_number(3, 1'b0);

    // Random part: mostly valid alphabets of random size and content.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      roll = $urandom_range(0, 19);
      flaw = FLAW_NONE;
      if (roll < 14) begin
        len = $urandom_range(MIN_RADIX, MAX_RADIX);
      end else if (roll < 16) begin
        len = $urandom_range(MAX_RADIX + 1, 31);
      end else if (roll < 17) begin
        len = $urandom_range(0, 1);
      end else begin
        len  = $urandom_range(MIN_RADIX, MAX_RADIX);
        flaw = flaw_t'($urandom_range(FLAW_REPEAT, FLAW_SIGN));
      end
      make_alphabet(len, flaw, lo, hi);
      reconfigure(lo, hi, length_word(len), $urandom_range(0, 3) == 0);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (k = 0; k < ITEMS_PER_PHASE; k++)
        send_number(pick_number((len > MAX_RADIX) ? MAX_RADIX : len),
                    (phase == 1 && k == 10) || $urandom_range(0, 39) == 0);
    end

    wait_quiet(DRAIN_SETTLE);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
